// ===== design/spr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the servo position ramp: register indexes,
// item modes, direction codes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package spr_pkg;

   localparam int POS_W   = 16;
   localparam int TICKS_W = 8;
   localparam int PROD_W  = POS_W + TICKS_W;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_US = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_MIN      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_MAX      = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLEW_STEP    = 8'd3;

   // Item modes.
   localparam logic MODE_TICK     = 1'b0;
   localparam logic MODE_SET_GOAL = 1'b1;

   // Reset values.
   localparam logic [TICKS_W-1:0] RESET_TICKS_PER_US = 8'd80;
   localparam logic [POS_W-1:0]   RESET_POS_MIN      = 16'd17750;
   localparam logic [POS_W-1:0]   RESET_POS_MAX      = 16'd19300;
   localparam logic [POS_W-1:0]   RESET_SLEW_STEP    = 16'd50;
   localparam logic [POS_W-1:0]   RESET_POSITION     = 16'd17650;
   localparam logic [POS_W-1:0]   RESET_GOAL         = 16'd19400;

   typedef enum logic [1:0] {
      DIR_IDLE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef struct packed {
      logic [TICKS_W-1:0] ticks_per_us;
      logic [POS_W-1:0]   pos_min;
      logic [POS_W-1:0]   pos_max;
      logic [POS_W-1:0]   slew_step;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      dir_type          dir;
   } step_type;

endpackage

// ===== design/spr_channel_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_channel_step
// One slew step of a single channel: moves the position toward its goal,
// retires the direction once the goal is reached, then clamps to the limits.
// ----------------------------------------------------------------------------
module spr_channel_step
   import spr_pkg::*;
(
   input  cfg_type          cfg,
   input  logic [POS_W-1:0] position,
   input  logic [POS_W-1:0] goal,
   input  dir_type          dir,
   output step_type         step
);

   logic [POS_W:0]   sum;
   logic [POS_W-1:0] down;
   logic [POS_W:0]   moved;
   logic [POS_W:0]   clamp_hi;
   logic [POS_W:0]   clamp_lo;
   dir_type          dir_next;

   always_comb begin
      sum  = {1'b0, position} + {1'b0, cfg.slew_step};
      down = (position > cfg.slew_step) ? (position - cfg.slew_step) : '0;
      case (dir)
         DIR_UP: begin
            moved    = sum;
            dir_next = (sum >= {1'b0, goal}) ? DIR_IDLE : DIR_UP;
         end
         DIR_DOWN: begin
            moved    = {1'b0, down};
            dir_next = (down <= goal) ? DIR_IDLE : DIR_DOWN;
         end
         default: begin
            moved    = {1'b0, position};
            dir_next = dir;
         end
      endcase
      // The upper clamp goes first so that pos_min wins when the limits cross.
      clamp_hi = (moved > {1'b0, cfg.pos_max}) ? {1'b0, cfg.pos_max} : moved;
      clamp_lo = (clamp_hi < {1'b0, cfg.pos_min}) ? {1'b0, cfg.pos_min} : clamp_hi;
      step.position = clamp_lo[POS_W-1:0];
      step.dir      = dir_next;
   end

endmodule

// ===== design/spr_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_scale
// Converts a pulse width in microseconds to timer counts and splits the
// count into the match word and the prescale byte.
// ----------------------------------------------------------------------------
module spr_scale
   import spr_pkg::*;
(
   input  logic [POS_W-1:0]   position,
   input  logic [TICKS_W-1:0] ticks_per_us,
   output logic [POS_W-1:0]   match_low,
   output logic [TICKS_W-1:0] prescale
);

   logic [PROD_W-1:0] product;

   // A 16 by 8 product never exceeds 255 above bit 16, so no saturation is needed.
   assign product   = PROD_W'(position) * PROD_W'(ticks_per_us);
   assign match_low = product[POS_W-1:0];
   assign prescale  = product[PROD_W-1:POS_W];

endmodule

// ===== design/servo_position_ramp_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_position_ramp_unit
// Slew-rate limited pulse widths for a set of servo channels.
// ----------------------------------------------------------------------------
// A set-goal item gives no result. A tick item walks the channels from the
// highest down to channel 0, one channel per cycle through the single step
// unit while the position stage can advance, so it holds the input stage until
// channel 0 is stepped and gives CHANNELS results, the last one flagged.
// Results pass a position register and then the scaling multiplier into the
// output register, and a new item is taken in the cycle its predecessor
// finishes. Configuration writes are always taken; they must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module servo_position_ramp_unit
   import spr_pkg::*;
#(
   parameter int CHANNELS = 2
)(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  logic                   req_channel,
   input  logic [POS_W-1:0]       req_goal,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_out_channel,
   output logic [POS_W-1:0]       rsp_position,
   output logic [POS_W-1:0]       rsp_match_low,
   output logic [TICKS_W-1:0]     rsp_prescale,
   output logic                   rsp_last,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   cfg_type cfg_ff;

   logic             item_valid_ff;
   logic             item_mode_ff;
   logic             item_channel_ff;
   logic [POS_W-1:0] item_goal_ff;
   logic [IDX_W-1:0] cnt_ff;

   logic [POS_W-1:0] pos_store_ff  [CHANNELS];
   logic [POS_W-1:0] goal_store_ff [CHANNELS];
   dir_type          dir_store_ff  [CHANNELS];

   logic             mid_valid_ff;
   logic [POS_W-1:0] mid_pos_ff;
   logic             mid_channel_ff;
   logic             mid_last_ff;

   logic               rsp_valid_ff;
   logic               rsp_out_channel_ff;
   logic [POS_W-1:0]   rsp_position_ff;
   logic [POS_W-1:0]   rsp_match_low_ff;
   logic [TICKS_W-1:0] rsp_prescale_ff;
   logic               rsp_last_ff;

   logic               rsp_adv;
   logic               mid_adv;
   logic               is_tick;
   logic               is_set;
   logic               chan_ok;
   logic               step_fire;
   logic               item_done;
   logic               req_fire;
   logic               csr_fire;
   logic [IDX_W-1:0]   rd_idx;
   logic [POS_W-1:0]   rd_pos;
   step_type           step;
   logic [POS_W-1:0]   scaled_match;
   logic [TICKS_W-1:0] scaled_prescale;

   assign rsp_adv   = !rsp_valid_ff || rsp_ready;
   assign mid_adv   = !mid_valid_ff || rsp_adv;
   assign is_tick   = item_valid_ff && (item_mode_ff == MODE_TICK);
   assign is_set    = item_valid_ff && (item_mode_ff == MODE_SET_GOAL);
   assign chan_ok   = (int'(item_channel_ff) < CHANNELS);
   assign step_fire = is_tick && mid_adv;
   assign item_done = is_set || (step_fire && (cnt_ff == '0));
   assign req_ready = !item_valid_ff || item_done;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // One read port serves both the tick walk and the set-goal compare.
   assign rd_idx = (is_set && chan_ok) ? IDX_W'(item_channel_ff) : cnt_ff;
   assign rd_pos = pos_store_ff[rd_idx];

   spr_channel_step u_step (
      .cfg      (cfg_ff),
      .position (rd_pos),
      .goal     (goal_store_ff[rd_idx]),
      .dir      (dir_store_ff[rd_idx]),
      .step     (step)
   );

   spr_scale u_scale (
      .position     (mid_pos_ff),
      .ticks_per_us (cfg_ff.ticks_per_us),
      .match_low    (scaled_match),
      .prescale     (scaled_prescale)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_us <= RESET_TICKS_PER_US;
         cfg_ff.pos_min      <= RESET_POS_MIN;
         cfg_ff.pos_max      <= RESET_POS_MAX;
         cfg_ff.slew_step    <= RESET_SLEW_STEP;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_TICKS_PER_US: cfg_ff.ticks_per_us <= csr_data[TICKS_W-1:0];
            CSR_POS_MIN:      cfg_ff.pos_min      <= csr_data[POS_W-1:0];
            CSR_POS_MAX:      cfg_ff.pos_max      <= csr_data[POS_W-1:0];
            CSR_SLEW_STEP:    cfg_ff.slew_step    <= csr_data[POS_W-1:0];
            default: ;
         endcase
      end
   end

   // Input stage and channel counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         if (req_fire) begin
            item_valid_ff <= 1'b1;
         end else if (item_done) begin
            item_valid_ff <= 1'b0;
         end
         if (req_fire && (req_mode == MODE_TICK)) begin
            cnt_ff <= IDX_W'(CHANNELS - 1);
         end else if (step_fire && (cnt_ff != '0)) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_mode_ff    <= req_mode;
         item_channel_ff <= req_channel;
         item_goal_ff    <= req_goal;
      end
   end

   // Channel state.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            pos_store_ff[i]  <= RESET_POSITION;
            goal_store_ff[i] <= RESET_GOAL;
            dir_store_ff[i]  <= DIR_IDLE;
         end
      end else if (is_set && chan_ok) begin
         goal_store_ff[rd_idx] <= item_goal_ff;
         if (item_goal_ff > rd_pos) begin
            dir_store_ff[rd_idx] <= DIR_UP;
         end else if (item_goal_ff < rd_pos) begin
            dir_store_ff[rd_idx] <= DIR_DOWN;
         end
      end else if (step_fire) begin
         pos_store_ff[rd_idx] <= step.position;
         dir_store_ff[rd_idx] <= step.dir;
      end
   end

   // Position stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (mid_adv) begin
         mid_valid_ff <= step_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         mid_pos_ff     <= step.position;
         mid_channel_ff <= cnt_ff[0];
         mid_last_ff    <= (cnt_ff == '0);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_adv) begin
         rsp_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_adv && mid_valid_ff) begin
         rsp_out_channel_ff <= mid_channel_ff;
         rsp_position_ff    <= mid_pos_ff;
         rsp_match_low_ff   <= scaled_match;
         rsp_prescale_ff    <= scaled_prescale;
         rsp_last_ff        <= mid_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_out_channel_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_match_low   = rsp_match_low_ff;
   assign rsp_prescale    = rsp_prescale_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   // A newly taken tick starts its walk at the highest channel.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_mode == MODE_TICK)) |=> (cnt_ff == IDX_W'(CHANNELS - 1)))
      else $error("tick walk did not start at the highest channel");

   // No new item is taken while a tick still has channels left to walk.
   assert property (@(posedge clock) disable iff (reset)
      (is_tick && (cnt_ff != '0)) |-> !req_ready)
      else $error("item taken in the middle of a tick walk");

   // The final result of a tick always belongs to channel 0.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_out_channel_ff == 1'b0))
      else $error("last flag on a result that is not channel 0");
`endif

endmodule

// ===== tb/servo_position_ramp_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_position_ramp_unit_tb
// Self-checking bench for the two-channel servo position ramp. A driver sends
// set-goal and tick items in bursts from a queue of pending commands. A
// predictor updates its own copy of positions, goals and directions on every
// accepted item, using its copy of the registers, and queues the expected pulse settings.
// A monitor takes results under a stall pattern and compares each one, field
// by field, with the oldest expected setting. The run steps through several
// register settings, among them the extremes, crossed limits, a zero step and
// a zero tick rate.
// ----------------------------------------------------------------------------
module servo_position_ramp_unit_tb;
   import spr_pkg::*;

   localparam int CHANNELS      = 2;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 8'hA5;

   typedef struct packed {
      logic             mode;
      logic             chan;
      logic [POS_W-1:0] goal;
   } servo_cmd_type;

   typedef struct packed {
      logic               chan;
      logic [POS_W-1:0]   position;
      logic [POS_W-1:0]   match_low;
      logic [TICKS_W-1:0] prescale;
      logic               last;
   } pulse_setting_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_mode = MODE_TICK;
   logic                   req_channel = 1'b0;
   logic [POS_W-1:0]       req_goal = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_out_channel;
   logic [POS_W-1:0]       rsp_position;
   logic [POS_W-1:0]       rsp_match_low;
   logic [TICKS_W-1:0]     rsp_prescale;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   servo_cmd_type     pending_cmds[$];
   pulse_setting_type expected_pulses[$];

   // Shadow of the block's registers and per-channel state.
   cfg_type          live_cfg;
   logic [POS_W-1:0] ramp_pos [CHANNELS];
   logic [POS_W-1:0] goal_target [CHANNELS];
   dir_type          ramp_dir [CHANNELS];

   int        error_count = 0;
   int        cmds_made = 0;
   bit        hold_item;
   bit        drain_hold;
   int        burst_left;
   int        gap_left;
   logic [15:0] ready_pattern = 16'hFFFF;
   logic [3:0]  rsp_beat;
   int          stall_left;

   servo_position_ramp_unit #(.CHANNELS(CHANNELS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_channel(req_channel), .req_goal(req_goal),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_channel(rsp_out_channel),
      .rsp_position(rsp_position), .rsp_match_low(rsp_match_low),
      .rsp_prescale(rsp_prescale), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one accepted item to the shadow state and queues its results.
   task automatic ramp_predict(input logic mode, input logic chan,
                               input logic [POS_W-1:0] goal);
      logic [POS_W:0]    next_pos;
      logic [PROD_W-1:0] counts;
      pulse_setting_type res;
      if (mode == MODE_SET_GOAL) begin
         goal_target[chan] = goal;
         if (goal > ramp_pos[chan]) ramp_dir[chan] = DIR_UP;
         else if (goal < ramp_pos[chan]) ramp_dir[chan] = DIR_DOWN;
      end else begin
         for (int ch = CHANNELS - 1; ch >= 0; ch--) begin
            next_pos = {1'b0, ramp_pos[ch]};
            if (ramp_dir[ch] == DIR_UP) begin
               // The sum is one bit wider so an overshoot still meets the goal test.
               next_pos = next_pos + {1'b0, live_cfg.slew_step};
               if (next_pos >= {1'b0, goal_target[ch]}) ramp_dir[ch] = DIR_IDLE;
            end else if (ramp_dir[ch] == DIR_DOWN) begin
               next_pos = (ramp_pos[ch] > live_cfg.slew_step) ?
                          {1'b0, ramp_pos[ch] - live_cfg.slew_step} : '0;
               if (next_pos <= {1'b0, goal_target[ch]}) ramp_dir[ch] = DIR_IDLE;
            end
            // The max clamp comes first, so the min limit wins when they cross.
            if (next_pos > {1'b0, live_cfg.pos_max}) next_pos = {1'b0, live_cfg.pos_max};
            if (next_pos < {1'b0, live_cfg.pos_min}) next_pos = {1'b0, live_cfg.pos_min};
            ramp_pos[ch] = next_pos[POS_W-1:0];
            counts = PROD_W'(ramp_pos[ch]) * PROD_W'(live_cfg.ticks_per_us);
            res.chan      = ch[0];
            res.position  = ramp_pos[ch];
            res.match_low = counts[POS_W-1:0];
            // A 16 by 8 bit product never carries above 255 in its top byte.
            res.prescale  = counts[PROD_W-1:POS_W];
            res.last      = (ch == 0);
            expected_pulses.push_back(res);
         end
      end
   endtask

   task automatic push_cmd(input logic mode, input logic chan, input logic [POS_W-1:0] goal);
      servo_cmd_type c;
      c.mode = mode;
      c.chan = chan;
      c.goal = goal;
      pending_cmds.push_back(c);
      cmds_made++;
   endtask

   task automatic push_tick();
      push_cmd(MODE_TICK, 1'($urandom_range(0, 1)), POS_W'($urandom_range(0, 65535)));
   endtask

   function automatic logic [POS_W-1:0] pick_goal();
      logic [POS_W-1:0] g;
      case ($urandom_range(0, 5))
         0: g = live_cfg.pos_min;
         1: g = live_cfg.pos_max;
         2: g = POS_W'($urandom_range(live_cfg.pos_min, live_cfg.pos_max));
         3: g = POS_W'(live_cfg.pos_min + $urandom_range(0, 4) - 2);
         default: g = POS_W'($urandom_range(0, 65535));
      endcase
      return g;
   endfunction

   // Mostly goal changes followed by a run of ticks, the rest loose items.
   task automatic fill_random(input int count);
      int start;
      start = cmds_made;
      while (cmds_made - start < count) begin
         if ($urandom_range(0, 9) < 7) begin
            push_cmd(MODE_SET_GOAL, 1'($urandom_range(0, 1)), pick_goal());
            if ($urandom_range(0, 2) == 0)
               push_cmd(MODE_SET_GOAL, 1'($urandom_range(0, 1)), pick_goal());
            repeat ($urandom_range(1, 10)) push_tick();
         end else begin
            push_cmd(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     POS_W'($urandom_range(0, 65535)));
         end
      end
   endtask

   // Must be called right after a rising edge; leaves the write channel idle.
   task automatic write_config(input logic [TICKS_W-1:0] ticks, input logic [POS_W-1:0] lo,
                               input logic [POS_W-1:0] hi, input logic [POS_W-1:0] step,
                               input bit poke_unused);
      logic [CSR_INDEX_W-1:0] idx [5];
      logic [CSR_DATA_W-1:0]  val [5];
      logic [CSR_DATA_W-1:0]  junk;
      int                     n;
      junk = CSR_DATA_W'($urandom_range(0, 65535));
      idx = '{CSR_TICKS_PER_US, CSR_POS_MIN, CSR_POS_MAX, CSR_SLEW_STEP, CSR_UNUSED};
      val = '{{8'h00, ticks}, lo, hi, step, junk};
      n = poke_unused ? 5 : 4;
      for (int i = 0; i < n; i++) begin
         csr_index <= idx[i];
         csr_data  <= val[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            CSR_TICKS_PER_US: live_cfg.ticks_per_us = val[i][TICKS_W-1:0];
            CSR_POS_MIN:      live_cfg.pos_min = val[i];
            CSR_POS_MAX:      live_cfg.pos_max = val[i];
            CSR_SLEW_STEP:    live_cfg.slew_step = val[i];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Set-goal items give no result, so the settle cycles cover the last one.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || hold_item || expected_pulses.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [TICKS_W-1:0] ticks, input logic [POS_W-1:0] lo,
                            input logic [POS_W-1:0] hi, input logic [POS_W-1:0] step,
                            input int count, input logic [15:0] pattern);
      write_config(ticks, lo, hi, step, $urandom_range(0, 3) == 0);
      ready_pattern = pattern | 16'h0001;
      fill_random(count);
      wait_drained();
   endtask

   // Request driver: bursts of items with random gaps, now and then a full drain.
   always @(posedge clock) begin
      servo_cmd_type c;
      if (reset) begin
         hold_item = 1'b0;
         drain_hold = 1'b0;
         burst_left = 0;
         gap_left = 0;
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            ramp_predict(req_mode, req_channel, req_goal);
            hold_item = 1'b0;
         end
         if (!hold_item) begin
            if (drain_hold) begin
               if (expected_pulses.size() == 0) drain_hold = 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
            end else if (pending_cmds.size() > 0) begin
               c = pending_cmds.pop_front();
               req_mode    <= c.mode;
               req_channel <= c.chan;
               req_goal    <= c.goal;
               hold_item = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else if ($urandom_range(0, 3) == 0) begin
                  burst_left = $urandom_range(20, 60);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(0, 8);
                  gap_left = $urandom_range(1, 6);
                  drain_hold = ($urandom_range(0, 39) == 0);
               end
            end
         end
         req_valid <= hold_item;
      end
   end

   // Result monitor and checker.
   always @(posedge clock) begin
      pulse_setting_type want;
      if (reset) begin
         rsp_beat = '0;
         stall_left = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pulses.size() == 0) begin
               $display("%0t: result with nothing expected, actual channel %0d position %0d",
                        $time, rsp_out_channel, rsp_position);
               error_count++;
            end else begin
               want = expected_pulses.pop_front();
               if (rsp_out_channel !== want.chan) begin
                  $display("%0t: out_channel expected %0d actual %0d",
                           $time, want.chan, rsp_out_channel);
                  error_count++;
               end
               if (rsp_position !== want.position) begin
                  $display("%0t: position expected %0d actual %0d",
                           $time, want.position, rsp_position);
                  error_count++;
               end
               if (rsp_match_low !== want.match_low) begin
                  $display("%0t: match_low expected %0d actual %0d",
                           $time, want.match_low, rsp_match_low);
                  error_count++;
               end
               if (rsp_prescale !== want.prescale) begin
                  $display("%0t: prescale expected %0d actual %0d",
                           $time, want.prescale, rsp_prescale);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %0d actual %0d",
                           $time, want.last, rsp_last);
                  error_count++;
               end
            end
         end
         rsp_beat = rsp_beat + 1'b1;
         if (stall_left > 0) stall_left--;
         else if ($urandom_range(0, 199) == 0) stall_left = $urandom_range(1, 30);
         rsp_ready <= (stall_left == 0) && ready_pattern[rsp_beat];
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      live_cfg.ticks_per_us = RESET_TICKS_PER_US;
      live_cfg.pos_min      = RESET_POS_MIN;
      live_cfg.pos_max      = RESET_POS_MAX;
      live_cfg.slew_step    = RESET_SLEW_STEP;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         ramp_pos[ch]    = RESET_POSITION;
         goal_target[ch] = RESET_GOAL;
         ramp_dir[ch]    = DIR_IDLE;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset values: the first tick lifts both channels onto the min limit.
      push_cmd(MODE_TICK, 1'b0, 16'h0000);
      push_cmd(MODE_SET_GOAL, 1'b0, 16'd17750);
      push_cmd(MODE_TICK, 1'b1, 16'hFFFF);
      // A goal equal to the position keeps the channel moving up.
      push_cmd(MODE_SET_GOAL, 1'b1, 16'd19400);
      push_cmd(MODE_SET_GOAL, 1'b1, 16'd17750);
      push_cmd(MODE_TICK, 1'b0, 16'h0000);
      push_cmd(MODE_SET_GOAL, 1'b0, 16'h0000);
      push_cmd(MODE_TICK, 1'b0, 16'h0000);
      push_cmd(MODE_SET_GOAL, 1'b1, 16'hFFFF);
      push_cmd(MODE_TICK, 1'b0, 16'h5555);
      push_cmd(MODE_TICK, 1'b1, 16'hAAAA);
      push_cmd(MODE_SET_GOAL, 1'b0, 16'h5555);
      push_cmd(MODE_SET_GOAL, 1'b1, 16'hAAAA);
      push_cmd(MODE_TICK, 1'b0, 16'h0000);
      push_cmd(MODE_SET_GOAL, 1'b0, 16'd19300);
      push_cmd(MODE_TICK, 1'b0, 16'h0000);
      push_cmd(MODE_TICK, 1'b0, 16'h0000);
      wait_drained();

      // Full range and the largest step: overshoot past the top, then a
      // downward step that saturates at zero.
      write_config(8'd255, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
      push_cmd(MODE_SET_GOAL, 1'b1, 16'hFFFF);
      push_cmd(MODE_TICK, 1'b0, 16'h0000);
      push_cmd(MODE_TICK, 1'b0, 16'h0000);
      push_cmd(MODE_SET_GOAL, 1'b0, 16'h0000);
      push_cmd(MODE_TICK, 1'b0, 16'h0000);
      wait_drained();
      ready_pattern = 16'hFFFF;
      fill_random(200);
      wait_drained();

      run_phase(RESET_TICKS_PER_US, RESET_POS_MIN, RESET_POS_MAX, RESET_SLEW_STEP,
                250, 16'h0F0F);
      run_phase(8'd1, 16'd0, 16'hFFFF, 16'd1, 200, 16'($urandom_range(0, 65535)));
      run_phase(8'd0, 16'd1000, 16'd2000, 16'd0, 150, 16'h8001);
      run_phase(8'd200, 16'd3000, 16'd1000, 16'd700, 200, 16'hFFFF);
      repeat (3) begin
         run_phase(TICKS_W'($urandom_range(1, 255)), POS_W'($urandom_range(0, 30000)),
                   POS_W'($urandom_range(30000, 65535)), POS_W'($urandom_range(1, 2000)),
                   250, 16'($urandom_range(0, 65535)));
      end
      run_phase(8'd255, 16'hFFFF, 16'hFFFF, 16'd300, 150, 16'h7777);
      run_phase(TICKS_W'($urandom_range(1, 255)), POS_W'($urandom_range(0, 65535)),
                POS_W'($urandom_range(0, 65535)), POS_W'($urandom_range(1, 65535)),
                150, 16'($urandom_range(0, 65535)));

      if (error_count == 0 && expected_pulses.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
